// File: rtl/mco_pkg.sv
package mco_pkg;

    localparam int MCO_MAX_LEN = 256;
    localparam int BASE_W      = 8;
    localparam int OUT_LEN_W   = 9;
    localparam int OUT_IDX_W   = 8;

    localparam logic [BASE_W-1:0] BASE_A = 8'h41;
    localparam logic [BASE_W-1:0] BASE_C = 8'h43;
    localparam logic [BASE_W-1:0] BASE_G = 8'h47;
    localparam logic [BASE_W-1:0] BASE_T = 8'h54;

    localparam logic REQ_FIRST  = 1'b0;
    localparam logic REQ_SECOND = 1'b1;

    function automatic logic pairs(input logic [BASE_W-1:0] x, input logic [BASE_W-1:0] y);
        pairs = (x == BASE_A && y == BASE_T) || (x == BASE_T && y == BASE_A) ||
                (x == BASE_C && y == BASE_G) || (x == BASE_G && y == BASE_C);
    endfunction

endpackage

// File: rtl/mco_cell.sv
module mco_cell import mco_pkg::*; #(
    parameter int P  = 0,
    parameter int IW = 8,
    parameter int LW = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clr,
    input  logic              i_we,
    input  logic [BASE_W-1:0] i_wbase,
    input  logic [LW-1:0]     i_first_len,
    input  logic              i_iv,
    input  logic [BASE_W-1:0] i_ib,
    input  logic [IW-1:0]     i_iidx,
    input  logic [LW-1:0]     i_run,
    input  logic [IW-1:0]     i_run_f,
    input  logic [IW-1:0]     i_run_s,
    input  logic [LW-1:0]     i_best,
    input  logic [IW-1:0]     i_best_f,
    input  logic [IW-1:0]     i_best_s,
    output logic              o_iv,
    output logic [BASE_W-1:0] o_ib,
    output logic [IW-1:0]     o_iidx,
    output logic [LW-1:0]     o_run,
    output logic [IW-1:0]     o_run_f,
    output logic [IW-1:0]     o_run_s,
    output logic [LW-1:0]     o_best,
    output logic [IW-1:0]     o_best_f,
    output logic [IW-1:0]     o_best_s
);

    localparam logic [LW-1:0] POS_L = LW'(P);
    localparam logic [IW-1:0] POS_I = IW'(P);

    logic [BASE_W-1:0] r_base;
    logic              r_iv;
    logic [BASE_W-1:0] r_ib;
    logic [IW-1:0]     r_iidx;

    logic [LW-1:0] r_run, r_dl_run, n_run;
    logic [IW-1:0] r_run_f, r_dl_run_f, n_run_f;
    logic [IW-1:0] r_run_s, r_dl_run_s, n_run_s;
    logic [LW-1:0] r_best, r_dl_best, n_best;
    logic [IW-1:0] r_best_f, r_dl_best_f, n_best_f;
    logic [IW-1:0] r_best_s, r_dl_best_s, n_best_s;

    logic pair;

    always_comb begin
        pair     = r_iv && (POS_L < i_first_len) && pairs(r_base, r_ib);
        n_run    = i_run;
        n_run_f  = i_run_f;
        n_run_s  = i_run_s;
        n_best   = i_best;
        n_best_f = i_best_f;
        n_best_s = i_best_s;
        if (pair) begin
            if (i_run == '0) begin
                n_run_f = POS_I;
                n_run_s = r_iidx;
            end
            n_run = i_run + LW'(1);
        end else begin
            if (i_run > i_best) begin
                n_best   = i_run;
                n_best_f = i_run_f;
                n_best_s = i_run_s;
            end
            n_run = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_base <= i_wbase;
        end
        r_ib   <= i_ib;
        r_iidx <= i_iidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_iv        <= 1'b0;
            r_run       <= '0;
            r_run_f     <= '0;
            r_run_s     <= '0;
            r_best      <= '0;
            r_best_f    <= '0;
            r_best_s    <= '0;
            r_dl_run    <= '0;
            r_dl_run_f  <= '0;
            r_dl_run_s  <= '0;
            r_dl_best   <= '0;
            r_dl_best_f <= '0;
            r_dl_best_s <= '0;
        end else begin
            r_iv        <= i_iv;
            r_run       <= n_run;
            r_run_f     <= n_run_f;
            r_run_s     <= n_run_s;
            r_best      <= n_best;
            r_best_f    <= n_best_f;
            r_best_s    <= n_best_s;
            r_dl_run    <= r_run;
            r_dl_run_f  <= r_run_f;
            r_dl_run_s  <= r_run_s;
            r_dl_best   <= r_best;
            r_dl_best_f <= r_best_f;
            r_dl_best_s <= r_best_s;
        end
    end

    // diagonal state passes through r_run and r_dl_run to the neighbour, the item through r_iv/r_ib only
    assign o_iv     = r_iv;
    assign o_ib     = r_ib;
    assign o_iidx   = r_iidx;
    assign o_run    = r_dl_run;
    assign o_run_f  = r_dl_run_f;
    assign o_run_s  = r_dl_run_s;
    assign o_best   = r_dl_best;
    assign o_best_f = r_dl_best_f;
    assign o_best_s = r_dl_best_s;

endmodule

// File: rtl/mco_feeder.sv
module mco_feeder import mco_pkg::*; #(
    parameter int N  = MCO_MAX_LEN,
    parameter int IW = 8,
    parameter int LW = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [IW-1:0]     i_waddr,
    input  logic [BASE_W-1:0] i_wdata,
    input  logic              i_start,
    input  logic [LW-1:0]     i_len,
    input  logic              i_rev,
    output logic              o_v,
    output logic [BASE_W-1:0] o_b,
    output logic [IW-1:0]     o_idx
);

    logic [BASE_W-1:0] mem [N];

    logic          r_busy;
    logic [IW-1:0] r_k;
    logic          r_v;
    logic [BASE_W-1:0] r_b;
    logic [IW-1:0] r_idx;

    logic [LW-1:0] len_m1;
    logic [LW-1:0] rev_addr;
    logic [IW-1:0] raddr;
    logic          at_end;

    always_comb begin
        len_m1   = i_len - LW'(1);
        rev_addr = len_m1 - LW'(r_k);
        raddr    = i_rev ? rev_addr[IW-1:0] : r_k;
        at_end   = (LW'(r_k) == len_m1);
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_b   <= mem[raddr];
        r_idx <= r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_v    <= 1'b0;
        end else begin
            r_v <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                if (at_end) begin
                    r_busy <= 1'b0;
                end
                r_k <= r_k + IW'(1);
            end
        end
    end

    assign o_v   = r_v;
    assign o_b   = r_b;
    assign o_idx = r_idx;

endmodule

// File: rtl/max_complementary_overlap.sv
// max_complementary_overlap
// Input channel: i_in_valid / o_in_stall with i_req_type, i_base, i_last. Bases of the
// first strand (req_type 0) and second strand (req_type 1) load one item per cycle
// while o_in_stall is low. A second-strand item with last set starts the scan;
// o_in_stall stays high until the result has been placed in the output register.
// Output channel: o_out_valid / i_out_stall with the run length, both start positions and
// the overflow flag. The result register holds while the receiver stalls, and loading of
// the next strands carries on meanwhile.
// Scan: after the last base, the scan runs until every diagonal has passed the full row
// of MAX_LEN compare cells, its end point depending on the second strand length; the
// second strand is streamed from its memory one base per cycle.
// Configuration: i_cfg_we with i_cfg_data writes reverse_second (reset value 1).
// Reset (synchronous, active low) empties both strands, clears overflow and drops any
// pending result. Stored bases are never cleared; only the lengths say what is valid.
module max_complementary_overlap import mco_pkg::*; #(
    parameter int MAX_LEN = MCO_MAX_LEN
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  logic [BASE_W-1:0]    i_base,
    input  logic                 i_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [OUT_LEN_W-1:0] o_max_overlap,
    output logic [OUT_IDX_W-1:0] o_first_start,
    output logic [OUT_IDX_W-1:0] o_second_start,
    output logic                 o_overflow
);

    localparam int N  = MAX_LEN;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int LW = $clog2(N + 1);
    localparam int CW = $clog2(3 * N + 6);
    localparam logic [LW-1:0] NL = LW'(N);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic          r_state;
    logic [CW-1:0] r_cnt;
    logic [LW-1:0] r_len1;
    logic [LW-1:0] r_len2;
    logic          r_ovf;
    logic          r_rev;
    logic [LW-1:0] r_best;
    logic [IW-1:0] r_best_f;
    logic [IW-1:0] r_best_s;
    logic          r_out_valid;
    logic [OUT_LEN_W-1:0] r_out_len;
    logic [OUT_IDX_W-1:0] r_out_f;
    logic [OUT_IDX_W-1:0] r_out_s;
    logic          r_out_ovf;

    logic          acc;
    logic          load1;
    logic          load2;
    logic          start;
    logic          clr;
    logic [CW-1:0] end_cnt;
    logic          scan_end;
    logic          deliver;

    logic [LW-1:0] cand_len;
    logic [IW-1:0] cand_f;
    logic [IW-1:0] cand_s;
    logic [LW+OUT_LEN_W-1:0] best_ext;
    logic [IW+OUT_IDX_W-1:0] bf_ext;
    logic [IW+OUT_IDX_W-1:0] bs_ext;

    logic              c_iv     [N+1];
    logic [BASE_W-1:0] c_ib     [N+1];
    logic [IW-1:0]     c_iidx   [N+1];
    logic [LW-1:0]     c_run    [N+1];
    logic [IW-1:0]     c_run_f  [N+1];
    logic [IW-1:0]     c_run_s  [N+1];
    logic [LW-1:0]     c_best   [N+1];
    logic [IW-1:0]     c_best_f [N+1];
    logic [IW-1:0]     c_best_s [N+1];
    logic              cell_we  [N];

    assign o_in_stall = (r_state == ST_SCAN);
    assign acc        = i_in_valid && !o_in_stall;
    assign load1      = acc && (i_req_type == REQ_FIRST) && (r_len1 < NL);
    assign load2      = acc && (i_req_type == REQ_SECOND) && (r_len2 < NL);
    assign start      = acc && (i_req_type == REQ_SECOND) && i_last;
    assign clr        = (r_state == ST_SCAN) && (r_cnt == '0);
    assign end_cnt    = CW'(r_len2) + CW'(2 * N + 4);
    assign scan_end   = (r_state == ST_SCAN) && (r_cnt == end_cnt);
    assign deliver    = scan_end && (!r_out_valid || !i_out_stall);

    mco_feeder #(
        .N  (N),
        .IW (IW),
        .LW (LW)
    ) u_feeder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (load2),
        .i_waddr (r_len2[IW-1:0]),
        .i_wdata (i_base),
        .i_start (clr),
        .i_len   (r_len2),
        .i_rev   (r_rev),
        .o_v     (c_iv[0]),
        .o_b     (c_ib[0]),
        .o_idx   (c_iidx[0])
    );

    assign c_run[0]    = '0;
    assign c_run_f[0]  = '0;
    assign c_run_s[0]  = '0;
    assign c_best[0]   = '0;
    assign c_best_f[0] = '0;
    assign c_best_s[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        assign cell_we[g] = load1 && (r_len1[IW-1:0] == IW'(g));

        mco_cell #(
            .P  (g),
            .IW (IW),
            .LW (LW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clr       (clr),
            .i_we        (cell_we[g]),
            .i_wbase     (i_base),
            .i_first_len (r_len1),
            .i_iv        (c_iv[g]),
            .i_ib        (c_ib[g]),
            .i_iidx      (c_iidx[g]),
            .i_run       (c_run[g]),
            .i_run_f     (c_run_f[g]),
            .i_run_s     (c_run_s[g]),
            .i_best      (c_best[g]),
            .i_best_f    (c_best_f[g]),
            .i_best_s    (c_best_s[g]),
            .o_iv        (c_iv[g+1]),
            .o_ib        (c_ib[g+1]),
            .o_iidx      (c_iidx[g+1]),
            .o_run       (c_run[g+1]),
            .o_run_f     (c_run_f[g+1]),
            .o_run_s     (c_run_s[g+1]),
            .o_best      (c_best[g+1]),
            .o_best_f    (c_best_f[g+1]),
            .o_best_s    (c_best_s[g+1])
        );
    end

    // close the open run of each diagonal leaving the row
    always_comb begin
        if (c_run[N] > c_best[N]) begin
            cand_len = c_run[N];
            cand_f   = c_run_f[N];
            cand_s   = c_run_s[N];
        end else begin
            cand_len = c_best[N];
            cand_f   = c_best_f[N];
            cand_s   = c_best_s[N];
        end
        best_ext = {{OUT_LEN_W{1'b0}}, r_best};
        bf_ext   = {{OUT_IDX_W{1'b0}}, r_best_f};
        bs_ext   = {{OUT_IDX_W{1'b0}}, r_best_s};
    end

    // diagonals leave in scan order, so only a strictly longer run wins
    always_ff @(posedge i_clk) begin
        if (clr) begin
            r_best   <= '0;
            r_best_f <= '0;
            r_best_s <= '0;
        end else if ((r_state == ST_SCAN) && !scan_end && (cand_len > r_best)) begin
            r_best   <= cand_len;
            r_best_f <= cand_f;
            r_best_s <= cand_s;
        end
        if (deliver) begin
            r_out_len <= best_ext[OUT_LEN_W-1:0];
            r_out_f   <= bf_ext[OUT_IDX_W-1:0];
            r_out_s   <= bs_ext[OUT_IDX_W-1:0];
            r_out_ovf <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_len1      <= '0;
            r_len2      <= '0;
            r_ovf       <= 1'b0;
            r_rev       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rev <= i_cfg_data;
            end
            if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        if (i_req_type == REQ_FIRST) begin
                            if (load1) begin
                                r_len1 <= r_len1 + LW'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end else begin
                            if (load2) begin
                                r_len2 <= r_len2 + LW'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                    end
                    if (start) begin
                        r_state <= ST_SCAN;
                        r_cnt   <= '0;
                    end
                end
                ST_SCAN: begin
                    if (!scan_end) begin
                        r_cnt <= r_cnt + CW'(1);
                    end else if (deliver) begin
                        r_out_valid <= 1'b1;
                        r_len1      <= '0;
                        r_len2      <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_max_overlap  = r_out_len;
    assign o_first_start  = r_out_f;
    assign o_second_start = r_out_s;
    assign o_overflow     = r_out_ovf;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len1 <= NL) && (r_len2 <= NL))
        else $error("strand length beyond storage");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_req_type && i_last) |=> (r_state == ST_SCAN))
        else $error("scan did not start after closing base");

    a_scan_holds_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && !deliver) |=> ($stable(r_len1) && $stable(r_len2)))
        else $error("strand length changed during scan");

    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_SCAN))
        else $error("result appeared outside a scan");

    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_best <= NL))
        else $error("best run longer than storage");

endmodule
